/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL files.
// Each macro expects i_clk and i_rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

/* rtl/psu_pkg.sv */
// ----------------------------------------------------------------------------
// psu_pkg
// Shared types, codes and the Paeth predictor for the scanline unfilter.
// ----------------------------------------------------------------------------
package psu_pkg;

    // filter type codes
    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;

    // configuration register indexes
    localparam int          CFG_IW          = 2;
    localparam logic [1:0]  REG_ROW_LENGTH  = 2'd0;
    localparam logic [1:0]  REG_PIXEL_BYTES = 2'd1;
    localparam int          ROW_LEN_W       = 14;
    localparam int          PIX_BYTES_W     = 3;

    // result status codes
    localparam logic STAT_OK         = 1'b0;
    localparam logic STAT_BAD_FILTER = 1'b1;

    // front-to-back queue depth
    localparam int Q_DEPTH = 2;

    // one queued work item
    typedef struct packed {
        logic [7:0] data;       // filtered byte
        logic [2:0] filter;     // filter of the current row
        logic       first_row;  // row above reads as zero
        logic       row_first;  // first data byte of a row
        logic       row_end;    // last data byte of a row
        logic       is_err;     // bad filter type result
    } t_entry;

    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic signed [9:0] da;
        logic signed [9:0] db;
        logic signed [9:0] dc;
        logic [9:0]        pa;
        logic [9:0]        pb;
        logic [9:0]        pc;
        // pa = |b - c|, pb = |a - c|, pc = |a + b - 2c|
        da = $signed({2'b00, b}) - $signed({2'b00, c});
        db = $signed({2'b00, a}) - $signed({2'b00, c});
        dc = da + db;
        pa = (da < 0) ? 10'(-da) : 10'(da);
        pb = (db < 0) ? 10'(-db) : 10'(db);
        pc = (dc < 0) ? 10'(-dc) : 10'(dc);
        if (pa <= pb && pa <= pc) begin
            return a;
        end else if (pb <= pc) begin
            return b;
        end
        return c;
    endfunction

endpackage

/* rtl/psu_queue.sv */
// ----------------------------------------------------------------------------
// psu_queue
// Short FIFO of work items between the front and back parts.
// ----------------------------------------------------------------------------
module psu_queue
    import psu_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_data,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_valid,
    output t_entry o_data
);
    `include "assert_macros.svh"

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_entry          r_q [Q_DEPTH];
    logic [PW-1:0]   r_wptr;
    logic [PW-1:0]   r_rptr;
    logic [CW-1:0]   r_count;

    assign o_full  = (r_count == CW'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `ASSERT_NEVER(a_no_push_full, i_push && o_full && !i_pop, "push into full queue")
    `ASSERT_NEVER(a_no_pop_empty, i_pop && !o_valid, "pop from empty queue")
    `ASSERT_CLK(a_count_up, i_push && !i_pop |=> r_count == $past(r_count) + CW'(1), "count slip")

endmodule

/* rtl/psu_front.sv */
// ----------------------------------------------------------------------------
// psu_front
// Accepts stream beats, tracks row position and filter, queues work items.
// ----------------------------------------------------------------------------
module psu_front
    import psu_pkg::*;
#(
    parameter int MAX_ROW_BYTES = 8192
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_stream_byte,
    input  logic                  i_frame_start,
    input  logic [ROW_LEN_W-1:0]  i_row_length,
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_entry                o_entry
);
    localparam int AW   = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int MW   = $clog2(MAX_ROW_BYTES + 1);
    localparam int LW   = (MW > ROW_LEN_W) ? MW : ROW_LEN_W;

    logic [AW-1:0] r_idx;
    logic [AW-1:0] n_idx;
    logic          r_in_row;
    logic          n_in_row;
    logic          r_first;
    logic          n_first;
    logic          r_err;
    logic          n_err;
    logic          r_row_first;
    logic          n_row_first;
    logic [2:0]    r_filter;
    logic [2:0]    n_filter;

    logic          accept;
    logic          want_filter;
    logic          first;
    logic          err;
    logic          bad;
    logic          row_end;
    logic [LW-1:0] len_raw;
    logic [LW-1:0] len_eff;
    logic [LW-1:0] pos_next;

    assign o_ready     = !i_q_full;
    assign accept      = i_valid && !i_q_full;
    assign want_filter = i_frame_start || !r_in_row;
    assign first       = i_frame_start || r_first;
    assign err         = !i_frame_start && r_err;
    assign bad         = (i_stream_byte > {5'd0, FILT_PAETH});

    // clamp length to 1..MAX_ROW_BYTES
    assign len_raw  = LW'(i_row_length);
    assign len_eff  = (len_raw == '0) ? LW'(1) :
                      (len_raw > LW'(MAX_ROW_BYTES)) ? LW'(MAX_ROW_BYTES) : len_raw;
    assign pos_next = LW'(r_idx) + LW'(1);
    assign row_end  = (pos_next >= len_eff);

    assign o_push = accept && !err && (!want_filter || bad);

    always_comb begin
        o_entry.data      = i_stream_byte;
        o_entry.filter    = r_filter;
        o_entry.first_row = first;
        o_entry.row_first = r_row_first;
        o_entry.row_end   = row_end;
        o_entry.is_err    = want_filter;
    end

    always_comb begin
        n_idx       = r_idx;
        n_in_row    = r_in_row;
        n_first     = r_first;
        n_err       = r_err;
        n_row_first = r_row_first;
        n_filter    = r_filter;
        if (accept) begin
            n_first  = first;
            n_err    = err;
            n_in_row = want_filter ? 1'b0 : r_in_row;
            if (!err) begin
                if (want_filter) begin
                    if (bad) begin
                        n_err = 1'b1;
                    end else begin
                        n_filter    = i_stream_byte[2:0];
                        n_in_row    = 1'b1;
                        n_idx       = '0;
                        n_row_first = 1'b1;
                    end
                end else begin
                    n_row_first = 1'b0;
                    if (row_end) begin
                        n_in_row = 1'b0;
                        n_first  = 1'b0;
                    end else begin
                        n_idx = AW'(pos_next);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_in_row    <= 1'b0;
            r_first     <= 1'b1;
            r_err       <= 1'b0;
            r_row_first <= 1'b0;
            r_filter    <= FILT_NONE;
        end else begin
            r_idx       <= n_idx;
            r_in_row    <= n_in_row;
            r_first     <= n_first;
            r_err       <= n_err;
            r_row_first <= n_row_first;
            r_filter    <= n_filter;
        end
    end

endmodule

/* rtl/psu_back.sv */
// ----------------------------------------------------------------------------
// psu_back
// Reads the line buffer, rebuilds bytes, writes the line buffer, holds results.
// ----------------------------------------------------------------------------
module psu_back
    import psu_pkg::*;
#(
    parameter int MAX_ROW_BYTES = 8192
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_valid,
    output logic                    o_q_pop,
    input  t_entry                  i_entry,
    input  logic [PIX_BYTES_W-1:0]  i_pixel_bytes,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [7:0]              o_pixel_byte,
    output logic                    o_row_end,
    output logic                    o_status
);
    `include "assert_macros.svh"

    localparam int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;

    // line buffer, undefined until written
    logic [7:0]    r_mem [MAX_ROW_BYTES];

    t_entry        r_a;
    logic          r_a_valid;
    logic [AW-1:0] r_a_idx;
    logic [AW-1:0] r_next_idx;
    logic [7:0]    r_rd;
    logic [31:0]   r_left;
    logic [31:0]   r_ul;
    logic          r_o_valid;
    logic [7:0]    r_o_byte;
    logic          r_o_row_end;
    logic          r_o_status;

    logic          a_adv;
    logic          a_wr;
    logic          fwd;
    logic [AW-1:0] idx_load;
    logic [1:0]    dsel;
    logic [31:0]   eff_left;
    logic [31:0]   eff_ul;
    logic [7:0]    nb_a;
    logic [7:0]    nb_b;
    logic [7:0]    nb_c;
    logic [8:0]    avg_sum;
    logic [7:0]    pred;
    logic [7:0]    value;

    assign a_adv    = r_a_valid && (!r_o_valid || i_ready);
    assign a_wr     = a_adv && !r_a.is_err;
    assign o_q_pop  = i_q_valid && (!r_a_valid || a_adv);
    assign idx_load = i_entry.row_first ? '0 : r_next_idx;
    // write to the same entry in this cycle bypasses the read
    assign fwd      = a_wr && (r_a_idx == idx_load);

    // clamp pixel size to 1..4
    assign dsel = (i_pixel_bytes == '0) ? 2'd0 :
                  (i_pixel_bytes > PIX_BYTES_W'(4)) ? 2'd3 : 2'(i_pixel_bytes - 1'b1);

    assign eff_left = r_a.row_first ? '0 : r_left;
    assign eff_ul   = r_a.row_first ? '0 : r_ul;
    assign nb_a     = eff_left[{dsel, 3'b000} +: 8];
    assign nb_c     = eff_ul[{dsel, 3'b000} +: 8];
    assign nb_b     = r_a.first_row ? 8'd0 : r_rd;
    assign avg_sum  = {1'b0, nb_a} + {1'b0, nb_b};

    always_comb begin
        case (r_a.filter)
            FILT_SUB:   pred = nb_a;
            FILT_UP:    pred = nb_b;
            FILT_AVG:   pred = avg_sum[8:1];
            FILT_PAETH: pred = paeth(nb_a, nb_b, nb_c);
            default:    pred = 8'd0;
        endcase
    end

    assign value = r_a.data + pred;

    always_ff @(posedge i_clk) begin
        if (a_wr) begin
            r_mem[r_a_idx] <= value;
        end
        if (o_q_pop) begin
            r_rd <= fwd ? value : r_mem[idx_load];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_a     <= i_entry;
            r_a_idx <= idx_load;
        end
        if (a_adv) begin
            r_o_byte    <= r_a.is_err ? 8'd0 : value;
            r_o_row_end <= !r_a.is_err && r_a.row_end;
            r_o_status  <= r_a.is_err ? STAT_BAD_FILTER : STAT_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid  <= 1'b0;
            r_next_idx <= '0;
            r_left     <= '0;
            r_ul       <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_a_valid <= 1'b1;
                if (!i_entry.is_err) begin
                    r_next_idx <= idx_load + 1'b1;
                end
            end else if (a_adv) begin
                r_a_valid <= 1'b0;
            end
            if (a_wr) begin
                r_left <= {eff_left[23:0], value};
                r_ul   <= {eff_ul[23:0], nb_b};
            end
            if (a_adv) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_o_valid;
    assign o_pixel_byte = r_o_byte;
    assign o_row_end    = r_o_row_end;
    assign o_status     = r_o_status;

    `ASSERT_NEVER(a_hold_rd, r_a_valid && !a_adv && o_q_pop, "line read lost in stall")
    `ASSERT_CLK(a_hold_a, r_a_valid && !a_adv |=> r_a_valid, "stage item dropped")
    `ASSERT_CLK(a_err_zero, r_o_valid && r_o_status |-> r_o_byte == 8'd0 && !r_o_row_end, "err payload")

endmodule

/* rtl/png_scanline_unfilter.sv */
// An input beat passes the queue, the rebuild stage and the output register.
// Throughput: one byte per cycle unless i_ready stalls; one line-buffer read and write port.
// Filter-type beats give no result, but a bad type gives an error result.
// Reset (i_rst_n low, synchronous): control state clears, row length and pixel size = 1.
// The line buffer has no clearing pass; each entry is written before the next row reads it.
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// PNG scanline filter reconstruction (None, Sub, Up, Average, Paeth), one
// byte per beat, with a line buffer holding the previous row.
// ----------------------------------------------------------------------------
module png_scanline_unfilter
    import psu_pkg::*;
#(
    parameter int MAX_ROW_BYTES = 8192
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_stream_byte,
    input  logic                  i_frame_start,
    // result stream
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_pixel_byte,
    output logic                  o_row_end,
    output logic                  o_status,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IW-1:0]     i_cfg_index,
    input  logic [ROW_LEN_W-1:0]  i_cfg_data
);

    // Configuration registers. Writes must come only while the block is idle; the
    // block does not enforce this. Front and back read them directly.
    logic [ROW_LEN_W-1:0]   r_row_length;
    logic [PIX_BYTES_W-1:0] r_pixel_bytes;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length  <= ROW_LEN_W'(1);
            r_pixel_bytes <= PIX_BYTES_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ROW_LENGTH:  r_row_length  <= i_cfg_data;
                REG_PIXEL_BYTES: r_pixel_bytes <= i_cfg_data[PIX_BYTES_W-1:0];
                default: ;
            endcase
        end
    end

    // Front: tracks row position, filter type and error state, and turns
    // every beat that yields a result into one queued work item.
    logic   q_full;
    logic   q_push;
    t_entry q_in;
    logic   q_valid;
    logic   q_pop;
    t_entry q_out;

    psu_front #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_stream_byte (i_stream_byte),
        .i_frame_start (i_frame_start),
        .i_row_length  (r_row_length),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_entry       (q_in)
    );

    // Two-entry queue: lets the input keep flowing while a result waits
    // on the output side.
    psu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    // Back: line-buffer read on pop, byte rebuild and write-back in the
    // next stage, then the output register. Left and upper-left windows
    // live here since they follow the rebuilt bytes.
    psu_back #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .o_q_pop       (q_pop),
        .i_entry       (q_out),
        .i_pixel_bytes (r_pixel_bytes),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pixel_byte  (o_pixel_byte),
        .o_row_end     (o_row_end),
        .o_status      (o_status)
    );

endmodule
